>>> sv/aosma_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aosma_pkg
// Shared types, constants and the mounting table for the accelerometer
// orientation, scaling and moving average core.
// ----------------------------------------------------------------------------
package aosma_pkg;

  // field widths
  localparam int unsigned RAW_W      = 8;
  localparam int unsigned AXIS_MAG_W = 12;
  localparam int unsigned AVG_W      = 26;
  localparam int unsigned ORIENT_W   = 3;
  localparam int unsigned NUM_AXES   = 3;

  // scaling: micrometres per second squared per lsb is GRAVITY_UM / 1024
  localparam int unsigned GRAVITY_UM  = 9806550;
  localparam int unsigned GRAVITY_W   = 24;
  localparam int unsigned SCALE_SHIFT = 10;
  localparam int unsigned PROD_W      = AXIS_MAG_W + GRAVITY_W;
  localparam int unsigned SCALED_W    = 25;
  localparam int unsigned RAW_OFFSET  = 32;

  // window and queue
  localparam int unsigned WINDOW_DEPTH_DEFAULT = 4;
  localparam int unsigned QUEUE_DEPTH          = 2;

  // configuration port
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  typedef enum logic [APB_ADDR_W-3:0] {
    REG_MOUNT_ORIENTATION = 1'b0
  } reg_idx_e;

  // per orientation sign flips, bit 0 is x, bit 1 is y, bit 2 is z
  localparam logic [NUM_AXES-1:0] ORIENT_NEG [8] = '{
    3'b000, 3'b010, 3'b011, 3'b001, 3'b101, 3'b111, 3'b110, 3'b100
  };

  // one axis as sign and magnitude
  typedef struct packed {
    logic                  neg;
    logic [AXIS_MAG_W-1:0] mag;
  } axis_t;

  // one remapped sample
  typedef struct packed {
    axis_t x;
    axis_t y;
    axis_t z;
  } item_t;

endpackage

>>> sv/aosma_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aosma_if
// Valid/ready channels for raw samples in and window averages out.
// ----------------------------------------------------------------------------
interface aosma_sample_if;
  logic                           valid;
  logic                           ready;
  logic [aosma_pkg::RAW_W-1:0]    raw_x;
  logic [aosma_pkg::RAW_W-1:0]    raw_y;
  logic [aosma_pkg::RAW_W-1:0]    raw_z;
  logic                           read_ok;

  modport source (output valid, output raw_x, output raw_y, output raw_z,
                  output read_ok, input ready);
  modport sink   (input valid, input raw_x, input raw_y, input raw_z,
                  input read_ok, output ready);
endinterface

interface aosma_result_if;
  logic                                valid;
  logic                                ready;
  logic signed [aosma_pkg::AVG_W-1:0]  avg_x;
  logic signed [aosma_pkg::AVG_W-1:0]  avg_y;
  logic signed [aosma_pkg::AVG_W-1:0]  avg_z;

  modport source (output valid, output avg_x, output avg_y, output avg_z,
                  input ready);
  modport sink   (input valid, input avg_x, input avg_y, input avg_z,
                  output ready);
endinterface

>>> sv/aosma_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aosma_front
// Takes raw sample beats, extracts the axis values and applies the mounting
// remap, leaving one sign/magnitude item per beat in a register.
// ----------------------------------------------------------------------------
module aosma_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  aosma_sample_if.sink                        sample_i,
  input  logic [aosma_pkg::ORIENT_W-1:0]      orient_i,
  output logic                                push_valid_o,
  output aosma_pkg::item_t                    push_item_o,
  input  logic                                push_ready_i
);

  // raw byte to sign and magnitude, zero on a failed read
  function automatic aosma_pkg::axis_t raw_to_axis(
    input logic [aosma_pkg::RAW_W-1:0] raw,
    input logic                        ok
  );
    logic signed [6:0]  cen;
    logic signed [12:0] val;
    aosma_pkg::axis_t   res;
    cen = $signed({1'b0, raw[7:2]}) - 7'(aosma_pkg::RAW_OFFSET);
    val = ok ? {cen, 6'b0} : '0;
    res.neg = val[12];
    res.mag = val[12] ? aosma_pkg::AXIS_MAG_W'(-val) : val[11:0];
    return res;
  endfunction

  aosma_pkg::axis_t            ax, ay, az;
  aosma_pkg::item_t            item_d;
  logic [aosma_pkg::NUM_AXES-1:0] flip;
  aosma_pkg::item_t            item_q;
  logic                        valid_q;
  logic                        take;

  // axis extraction and remap
  always_comb begin
    ax   = raw_to_axis(sample_i.raw_x, sample_i.read_ok);
    ay   = raw_to_axis(sample_i.raw_y, sample_i.read_ok);
    az   = raw_to_axis(sample_i.raw_z, sample_i.read_ok);
    flip = aosma_pkg::ORIENT_NEG[orient_i];
    item_d.x     = orient_i[0] ? ay : ax;
    item_d.y     = orient_i[0] ? ax : ay;
    item_d.z     = az;
    item_d.x.neg = item_d.x.neg ^ flip[0];
    item_d.y.neg = item_d.y.neg ^ flip[1];
    item_d.z.neg = item_d.z.neg ^ flip[2];
  end

  // holding register, refilled as soon as the queue takes the item
  assign sample_i.ready = !valid_q || push_ready_i;
  assign take           = sample_i.valid && sample_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (sample_i.ready) begin
      valid_q <= sample_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_d;
    end
  end

  assign push_valid_o = valid_q;
  assign push_item_o  = item_q;

endmodule

>>> sv/aosma_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aosma_fifo
// Short queue of remapped items between the front and the back.
// ----------------------------------------------------------------------------
module aosma_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  input  aosma_pkg::item_t  push_item_i,
  output logic              push_ready_o,
  output logic              pop_valid_o,
  output aosma_pkg::item_t  pop_item_o,
  input  logic              pop_ready_i
);

  localparam int unsigned PTR_W = $clog2(aosma_pkg::QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(aosma_pkg::QUEUE_DEPTH + 1);

  aosma_pkg::item_t  slot_q [aosma_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  count_q;
  logic              push, pop;

  assign push_ready_o = count_q != CNT_W'(aosma_pkg::QUEUE_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign pop_item_o   = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(aosma_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(aosma_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

>>> sv/aosma_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aosma_back
// Scaling, sliding window sums and truncating average, five stages that all
// advance together whenever the output register can move.
// ----------------------------------------------------------------------------
module aosma_back #(
  parameter int unsigned WINDOW_DEPTH = aosma_pkg::WINDOW_DEPTH_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              pop_valid_i,
  input  aosma_pkg::item_t  pop_item_i,
  output logic              pop_ready_o,
  aosma_result_if.source    result_o
);

  localparam int unsigned NA      = aosma_pkg::NUM_AXES;
  localparam int unsigned AW      = aosma_pkg::AVG_W;
  localparam int unsigned SUM_W   = AW + $clog2(WINDOW_DEPTH);
  localparam int unsigned MAG_W   = SUM_W - 1;
  localparam int unsigned RECIP_W = 32;
  localparam int unsigned DPROD_W = MAG_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_W) / 64'(WINDOW_DEPTH));
  localparam logic [MAG_W-1:0]   DEPTH_M = MAG_W'(WINDOW_DEPTH);

  aosma_pkg::axis_t lane_in [NA];

  logic                                   adv;
  logic                                   s1_valid_q, s2_valid_q, s3_valid_q;
  logic                                   s4_valid_q, out_valid_q;
  logic [NA-1:0]                          s1_neg_q, s4_neg_q;
  logic [aosma_pkg::SCALED_W-1:0]         s1_scaled_q [NA];
  logic signed [AW-1:0]                   s2_val_q [NA];
  logic signed [AW-1:0]                   win_q [NA][WINDOW_DEPTH];
  logic signed [SUM_W-1:0]                sum_q [NA];
  logic [MAG_W-1:0]                       s4_mag_q [NA];
  logic [DPROD_W-1:0]                     s4_prod_q [NA];
  logic signed [AW-1:0]                   avg_q [NA];

  logic [aosma_pkg::PROD_W-1:0]           prod1 [NA];
  logic signed [AW-1:0]                   pos2 [NA];
  logic signed [AW-1:0]                   val2 [NA];
  logic signed [SUM_W-1:0]                sum3 [NA];
  logic [MAG_W-1:0]                       mag4 [NA];
  logic [MAG_W-1:0]                       q0_5 [NA];
  logic [MAG_W-1:0]                       rem5 [NA];
  logic [MAG_W-1:0]                       quo5 [NA];
  logic signed [AW-1:0]                   quoa5 [NA];
  logic signed [AW-1:0]                   avg5 [NA];

  assign lane_in[0] = pop_item_i.x;
  assign lane_in[1] = pop_item_i.y;
  assign lane_in[2] = pop_item_i.z;

  // whole pipeline moves when the output register is free or being taken
  assign adv         = !out_valid_q || result_o.ready;
  assign pop_ready_o = adv;

  // datapath per axis
  always_comb begin
    for (int a = 0; a < NA; a++) begin
      // magnitude times gravity, truncation toward zero by shifting magnitude
      prod1[a] = aosma_pkg::PROD_W'(lane_in[a].mag)
               * aosma_pkg::PROD_W'(aosma_pkg::GRAVITY_UM);
      // restore sign
      pos2[a]  = $signed({1'b0, s1_scaled_q[a]});
      val2[a]  = s1_neg_q[a] ? -pos2[a] : pos2[a];
      // running sum: drop the oldest entry, add the new one
      sum3[a]  = sum_q[a] - SUM_W'(win_q[a][WINDOW_DEPTH-1]) + SUM_W'(s2_val_q[a]);
      // magnitude of the sum for the reciprocal multiply
      mag4[a]  = sum_q[a][SUM_W-1] ? MAG_W'(-sum_q[a]) : MAG_W'(sum_q[a]);
      // quotient estimate is exact or one low
      q0_5[a]  = s4_prod_q[a][RECIP_W +: MAG_W];
      rem5[a]  = s4_mag_q[a] - q0_5[a] * DEPTH_M;
      quo5[a]  = (rem5[a] >= DEPTH_M) ? q0_5[a] + 1'b1 : q0_5[a];
      quoa5[a] = $signed(AW'(quo5[a]));
      avg5[a]  = s4_neg_q[a] ? -quoa5[a] : quoa5[a];
    end
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= pop_valid_i;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      s4_valid_q  <= s3_valid_q;
      out_valid_q <= s4_valid_q;
    end
  end

  // window store and running sums, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < NA; a++) begin
        sum_q[a] <= '0;
        for (int k = 0; k < WINDOW_DEPTH; k++) begin
          win_q[a][k] <= '0;
        end
      end
    end else if (adv && s2_valid_q) begin
      for (int a = 0; a < NA; a++) begin
        sum_q[a]    <= sum3[a];
        win_q[a][0] <= s2_val_q[a];
        for (int k = 1; k < WINDOW_DEPTH; k++) begin
          win_q[a][k] <= win_q[a][k-1];
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int a = 0; a < NA; a++) begin
        if (pop_valid_i) begin
          s1_neg_q[a]    <= lane_in[a].neg;
          s1_scaled_q[a] <= prod1[a][aosma_pkg::SCALE_SHIFT +: aosma_pkg::SCALED_W];
        end
        if (s1_valid_q) begin
          s2_val_q[a] <= val2[a];
        end
        if (s3_valid_q) begin
          s4_neg_q[a]  <= sum_q[a][SUM_W-1];
          s4_mag_q[a]  <= mag4[a];
          s4_prod_q[a] <= DPROD_W'(mag4[a]) * DPROD_W'(RECIP);
        end
        if (s4_valid_q) begin
          avg_q[a] <= avg5[a];
        end
      end
    end
  end

  assign result_o.valid = out_valid_q;
  assign result_o.avg_x = avg_q[0];
  assign result_o.avg_y = avg_q[1];
  assign result_o.avg_z = avg_q[2];

endmodule

>>> sv/accel_orient_scale_moving_average_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accel_orient_scale_moving_average_core
// Accelerometer sample conditioner: mounting remap, scaling to micrometres
// per second squared and a sliding window average per axis.
//
// Usage:
//   sample_i carries one raw sample per beat (three axis bytes and a read ok
//   flag); result_o carries one beat of three window averages per sample,
//   in order. Both are valid/ready channels.
//   The APB port holds the mounting orientation register at offset 0; it is to be
//   written while no sample is in flight, a rule the block itself does not enforce.
//   Throughput is one sample per cycle while result_o is ready. A sample passes
//   through the front register, queue, scaling multiply, sign, window sum
//   update, reciprocal multiply and output register, in that order.
//   When result_o stalls, the back stages hold, the two entry queue fills,
//   then the front register, and sample_i.ready drops; nothing is lost.
//   Reset clears the orientation to zero, the windows and the running sums;
//   unwritten window entries count as zero in the average.
// ----------------------------------------------------------------------------
module accel_orient_scale_moving_average_core #(
  parameter int unsigned WINDOW_DEPTH = aosma_pkg::WINDOW_DEPTH_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  aosma_sample_if.sink                        sample_i,
  aosma_result_if.source                      result_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [aosma_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [aosma_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [aosma_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                pready
);

  logic [aosma_pkg::ORIENT_W-1:0] orient_q;
  logic                           reg_hit;
  logic                           push_valid, push_ready;
  logic                           pop_valid, pop_ready;
  aosma_pkg::item_t               push_item, pop_item;

  // configuration register
  assign pready  = 1'b1;
  assign reg_hit = paddr[aosma_pkg::APB_ADDR_W-1:2] == aosma_pkg::REG_MOUNT_ORIENTATION;
  assign prdata  = reg_hit ? aosma_pkg::APB_DATA_W'(orient_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      orient_q <= '0;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      orient_q <= pwdata[aosma_pkg::ORIENT_W-1:0];
    end
  end

  // front: extraction and remap
  aosma_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sample_i     (sample_i),
    .orient_i     (orient_q),
    .push_valid_o (push_valid),
    .push_item_o  (push_item),
    .push_ready_i (push_ready)
  );

  // decoupling queue
  aosma_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_item_i  (push_item),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_item_o   (pop_item),
    .pop_ready_i  (pop_ready)
  );

  // back: scaling and averaging
  aosma_back #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_item_i  (pop_item),
    .pop_ready_o (pop_ready),
    .result_o    (result_o)
  );

endmodule

>>> tb/tb_accel_orient_scale_moving_average_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_accel_orient_scale_moving_average_core
// Self-checking bench for the accelerometer conditioner. Raw sample beats go
// in over the sample channel and each accepted beat is run through a local
// predictor (offset removal, mounting remap, scaling, four-deep window
// average). The expected averages are queued and compared field by field with
// every accepted result beat. The mounting register is changed over APB
// between phases while the core is idle, and both channels are throttled at
// random, with one long hold on the result side to fill the pipeline.
// ----------------------------------------------------------------------------
module tb_accel_orient_scale_moving_average_core;

  localparam int unsigned RAW_W      = aosma_pkg::RAW_W;
  localparam int unsigned AVG_W      = aosma_pkg::AVG_W;
  localparam int unsigned ORIENT_W   = aosma_pkg::ORIENT_W;
  localparam int unsigned NUM_AXES   = aosma_pkg::NUM_AXES;
  localparam int unsigned APB_ADDR_W = aosma_pkg::APB_ADDR_W;
  localparam int unsigned APB_DATA_W = aosma_pkg::APB_DATA_W;
  localparam int unsigned JUNK_W     = APB_DATA_W - ORIENT_W;

  localparam int unsigned WIN           = aosma_pkg::WINDOW_DEPTH_DEFAULT;
  localparam int unsigned CLK_PERIOD    = 8;
  localparam int unsigned RESET_CYCLES  = 10;
  localparam int unsigned LATENCY       = 6;
  localparam int unsigned SETTLE_CYCLES = 2 * LATENCY + 4;
  localparam longint      CYCLE_LIMIT   = 500000;
  localparam longint      SCALE_DIV     = longint'(1) << aosma_pkg::SCALE_SHIFT;
  localparam int unsigned UNUSED_REG_IDX = 1;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned PHASE_BEATS   = 200;
  localparam int unsigned HOLD_BEATS    = 40;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned MAX_PRINTED   = 30;

  localparam logic [APB_ADDR_W-1:0] MOUNT_ADDR  = {aosma_pkg::REG_MOUNT_ORIENTATION, 2'b00};
  localparam logic [APB_ADDR_W-1:0] UNUSED_ADDR = APB_ADDR_W'(UNUSED_REG_IDX * 4);

  // mounting options: face up or face down, rotated in steps of 90 degrees
  typedef enum logic [ORIENT_W-1:0] {
    MNT_UP_0     = 3'd0,
    MNT_UP_90    = 3'd1,
    MNT_UP_180   = 3'd2,
    MNT_UP_270   = 3'd3,
    MNT_DOWN_0   = 3'd4,
    MNT_DOWN_90  = 3'd5,
    MNT_DOWN_180 = 3'd6,
    MNT_DOWN_270 = 3'd7
  } mount_e;

  typedef enum int {
    RX_ALWAYS,
    RX_COIN,
    RX_RARE_STALL,
    RX_PATTERN
  } rx_mode_e;

  typedef struct packed {
    logic [RAW_W-1:0] x, y, z;
    logic             ok;
  } sample_t;

  typedef struct packed {
    logic signed [AVG_W-1:0] x, y, z;
  } avg_beat_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  aosma_sample_if sample_ch ();
  aosma_result_if result_ch ();

  accel_orient_scale_moving_average_core dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_ch),
    .result_o (result_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // predictor state
  logic [ORIENT_W-1:0]     mount_sel;
  logic signed [AVG_W-1:0] window_hist [NUM_AXES][WIN];
  logic signed [AVG_W+1:0] window_acc [NUM_AXES];
  logic [$clog2(WIN)-1:0]  window_slot;
  avg_beat_t               expected_avgs [$];

  // stimulus pacing and receiver control
  bit          gaps_on;
  int          burst_left;
  rx_mode_e    rx_mode;
  logic [15:0] stall_pattern;
  int unsigned hold_request;
  int unsigned hold_left;
  int unsigned mismatch_count;
  longint      cycle_count;

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTED) $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // bits 7:2 carry the sample, centred on the offset
  function automatic int raw_to_counts(input logic [RAW_W-1:0] b);
    int u;
    u = b[RAW_W-1:2];
    return (u - int'(aosma_pkg::RAW_OFFSET)) * 64;
  endfunction

  // counts to micrometres per second squared, truncated toward zero
  function automatic longint counts_to_micro(input int a);
    return (longint'(a) * longint'(aosma_pkg::GRAVITY_UM)) / SCALE_DIV;
  endfunction

  function automatic void predict_average(input sample_t s);
    int        raw [NUM_AXES];
    int        mounted [NUM_AXES];
    longint    scaled;
    longint    acc;
    longint    avg [NUM_AXES];
    avg_beat_t beat;
    raw[0] = s.ok ? raw_to_counts(s.x) : 0;
    raw[1] = s.ok ? raw_to_counts(s.y) : 0;
    raw[2] = s.ok ? raw_to_counts(s.z) : 0;
    // mounting remap
    case (mount_e'(mount_sel))
      MNT_UP_0:     mounted = '{ raw[0],  raw[1],  raw[2]};
      MNT_UP_90:    mounted = '{ raw[1], -raw[0],  raw[2]};
      MNT_UP_180:   mounted = '{-raw[0], -raw[1],  raw[2]};
      MNT_UP_270:   mounted = '{-raw[1],  raw[0],  raw[2]};
      MNT_DOWN_0:   mounted = '{-raw[0],  raw[1], -raw[2]};
      MNT_DOWN_90:  mounted = '{-raw[1], -raw[0], -raw[2]};
      MNT_DOWN_180: mounted = '{ raw[0], -raw[1], -raw[2]};
      default:      mounted = '{ raw[1],  raw[0], -raw[2]};
    endcase
    // replace the oldest window entry and keep the running sum in step
    for (int i = 0; i < NUM_AXES; i++) begin
      scaled = counts_to_micro(mounted[i]);
      acc = longint'(window_acc[i]) - longint'(window_hist[i][window_slot]) + scaled;
      window_hist[i][window_slot] = scaled[AVG_W-1:0];
      window_acc[i] = acc[AVG_W+1:0];
      avg[i] = acc / longint'(WIN);
    end
    window_slot = (window_slot == WIN - 1) ? '0 : window_slot + 1'b1;
    beat.x = avg[0][AVG_W-1:0];
    beat.y = avg[1][AVG_W-1:0];
    beat.z = avg[2][AVG_W-1:0];
    expected_avgs.push_back(beat);
  endfunction

  // random gaps between bursts of back-to-back beats
  task automatic pace_sender();
    int gap;
    if (!gaps_on) return;
    burst_left--;
    if (burst_left <= 0) begin
      gap = $urandom_range(1, 8);
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
  endtask

  task automatic send_sample(input sample_t s);
    sample_ch.valid   <= 1'b1;
    sample_ch.raw_x   <= s.x;
    sample_ch.raw_y   <= s.y;
    sample_ch.raw_z   <= s.z;
    sample_ch.read_ok <= s.ok;
    do @(posedge clk_i); while (sample_ch.ready !== 1'b1);
    predict_average(s);
    pace_sender();
  endtask

  // stop sending and let every outstanding beat come out
  task automatic quiesce();
    sample_ch.valid <= 1'b0;
    do @(posedge clk_i); while (expected_avgs.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [APB_ADDR_W-1:0] addr,
                           input logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr[APB_ADDR_W-1:2] == aosma_pkg::REG_MOUNT_ORIENTATION)
      mount_sel = data[ORIENT_W-1:0];
    @(posedge clk_i);
  endtask

  task automatic reg_read_check(input logic [APB_ADDR_W-1:0] addr,
                                input logic [APB_DATA_W-1:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== want)
      report_mismatch($sformatf("register read at %0d got %0h want %0h", addr, prdata, want));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_mount(input mount_e m, input logic [JUNK_W-1:0] junk);
    quiesce();
    reg_write(MOUNT_ADDR, {junk, m});
    reg_read_check(MOUNT_ADDR, APB_DATA_W'(m));
  endtask

  function automatic logic [RAW_W-1:0] edge_byte();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hff;
      2:       return 8'h80;
      3:       return 8'h7f;
      4:       return 8'h83;
      default: return 8'h03;
    endcase
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    if ($urandom_range(0, 3) == 0) begin
      s.x = edge_byte();
      s.y = edge_byte();
      s.z = edge_byte();
    end else begin
      s.x = RAW_W'($urandom);
      s.y = RAW_W'($urandom);
      s.z = RAW_W'($urandom);
    end
    s.ok = ($urandom_range(0, 7) != 0);
    return s;
  endfunction

  // window filling from reset, full-scale bytes and failed reads
  task automatic test_window_fill();
    reg_read_check(MOUNT_ADDR, APB_DATA_W'(MNT_UP_0));
    rx_mode = RX_ALWAYS;
    gaps_on = 1'b0;
    send_sample('{x: 8'h00, y: 8'h00, z: 8'h00, ok: 1'b1});
    send_sample('{x: 8'hff, y: 8'hff, z: 8'hff, ok: 1'b1});
    send_sample('{x: 8'h80, y: 8'h83, z: 8'h7f, ok: 1'b1});
    send_sample('{x: 8'hff, y: 8'h00, z: 8'h80, ok: 1'b0});
    send_sample('{x: 8'h00, y: 8'hff, z: 8'h03, ok: 1'b1});
    send_sample('{x: 8'h7c, y: 8'hfc, z: 8'h01, ok: 1'b1});
  endtask

  // every mounting option with asymmetric full-scale axes
  task automatic test_mount_table();
    mount_e m;
    m = m.first();
    do begin
      set_mount(m, '0);
      send_sample('{x: 8'h00, y: 8'hff, z: 8'h40, ok: 1'b1});
      send_sample('{x: 8'hff, y: 8'h00, z: 8'hc0, ok: 1'b1});
      m = m.next();
    end while (m != m.first());
  endtask

  // long random streams under varied mounting and throttling
  task automatic test_random_streams();
    mount_e m;
    logic [JUNK_W-1:0] junk;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0:       begin m = MNT_DOWN_270; junk = '1; end
        1:       begin m = MNT_UP_0;     junk = '1; end
        2:       begin m = mount_e'($urandom_range(0, 7)); junk = '0; end
        default: begin m = mount_e'($urandom_range(0, 7)); junk = JUNK_W'($urandom); end
      endcase
      set_mount(m, junk);
      // a write to an unmapped register must leave the mounting alone
      if (p == 0) begin
        reg_write(UNUSED_ADDR, APB_DATA_W'(MNT_UP_180));
        reg_read_check(MOUNT_ADDR, APB_DATA_W'(m));
      end
      rx_mode = rx_mode_e'(p % 4);
      stall_pattern = 16'($urandom) | 16'h0001;
      gaps_on = (p % 3 != 2);
      burst_left = $urandom_range(1, 12);
      repeat (PHASE_BEATS) send_sample(random_sample());
    end
  endtask

  // long result stall while samples keep coming, so the input backs up
  task automatic test_backpressure();
    quiesce();
    rx_mode = RX_ALWAYS;
    gaps_on = 1'b0;
    hold_request = HOLD_CYCLES;
    repeat (HOLD_BEATS) send_sample(random_sample());
  endtask

  // result side ready generator
  always @(posedge clk_i) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      result_ch.ready <= 1'b0;
      hold_left--;
    end else begin
      case (rx_mode)
        RX_ALWAYS:     result_ch.ready <= 1'b1;
        RX_COIN:       result_ch.ready <= 1'($urandom_range(0, 1));
        RX_RARE_STALL: result_ch.ready <= ($urandom_range(0, 7) != 0);
        default: begin
          result_ch.ready <= stall_pattern[0];
          stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
        end
      endcase
    end
  end

  // result checker
  always @(posedge clk_i) begin
    avg_beat_t want;
    if (rst_ni && result_ch.valid && result_ch.ready) begin
      if (expected_avgs.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = expected_avgs.pop_front();
        if (result_ch.avg_x !== want.x)
          report_mismatch($sformatf("avg_x got %0d want %0d", result_ch.avg_x, want.x));
        if (result_ch.avg_y !== want.y)
          report_mismatch($sformatf("avg_y got %0d want %0d", result_ch.avg_y, want.y));
        if (result_ch.avg_z !== want.z)
          report_mismatch($sformatf("avg_z got %0d want %0d", result_ch.avg_z, want.z));
      end
    end
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    rst_ni            <= 1'b0;
    sample_ch.valid   <= 1'b0;
    sample_ch.raw_x   <= '0;
    sample_ch.raw_y   <= '0;
    sample_ch.raw_z   <= '0;
    sample_ch.read_ok <= 1'b0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    rx_mode        = RX_ALWAYS;
    stall_pattern  = 16'h00ff;
    hold_request   = 0;
    gaps_on        = 1'b0;
    burst_left     = 1;
    mismatch_count = 0;
    // predictor mirrors the reset state
    mount_sel   = MNT_UP_0;
    window_slot = '0;
    for (int i = 0; i < NUM_AXES; i++) begin
      window_acc[i] = '0;
      for (int j = 0; j < WIN; j++) window_hist[i][j] = '0;
    end
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_window_fill();
    test_mount_table();
    test_random_streams();
    test_backpressure();
    quiesce();

    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
